// ===== design/slfw_pkg.sv =====
// Package for the segment LCD serial frame writer.
// Holds frame sizes, the digit segment table and the frame word type.
// No dependencies.
`timescale 1ns / 1ps

package slfw_pkg;

  localparam int unsigned DIGIT_COUNT = 4;
  localparam int unsigned VALUE_W     = 14;
  localparam int unsigned CMD_W       = 8;
  localparam int unsigned BCD_W       = 4 * DIGIT_COUNT;
  localparam int unsigned FRAME_W     = 3 + 6 + 8 * DIGIT_COUNT;
  localparam int unsigned CMD_LEN     = 4 + CMD_W;
  localparam int unsigned LEN_W       = $clog2(FRAME_W + 1);
  localparam int unsigned CMP_W       = 20;

  localparam logic [3:0] CMD_HEAD  = 4'b1000;
  localparam logic [2:0] DISP_HEAD = 3'b101;
  localparam logic [7:0] POINT_SEG = 8'h10;

  function automatic int unsigned pow10(input int unsigned n);
    int unsigned r;
    r = 1;
    for (int unsigned i = 0; i < n; i++) begin
      r = r * 10;
    end
    return r;
  endfunction

  localparam int unsigned MAX_VALUE = pow10(DIGIT_COUNT) - 1;

  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] s;
    unique case (digit)
      4'd0:    s = 8'heb;
      4'd1:    s = 8'h0a;
      4'd2:    s = 8'had;
      4'd3:    s = 8'h8f;
      4'd4:    s = 8'h4e;
      4'd5:    s = 8'hc7;
      4'd6:    s = 8'he7;
      4'd7:    s = 8'h8a;
      4'd8:    s = 8'hef;
      4'd9:    s = 8'hcf;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  typedef struct packed {
    logic [FRAME_W-1:0] bits;
    logic [LEN_W-1:0]   len;
  } frame_t;

endpackage

// ===== design/segment_lcd_serial_frame_writer.sv =====
// Segment LCD serial frame writer: request in, one serial bit per cycle out.
// Built from slfw_front, slfw_queue and slfw_back; depends on slfw_pkg.
//
// Usage: drive kind_i, command_byte_i, value_i and point_flag_i and raise
// start; the request is taken on a rising edge where start is high and busy
// is low. A command request yields 12 bits (1000 then the command byte); a
// display request yields 41 bits (101, six zeros, four segment codes,
// thousands first), with values above 9999 clamped.
// Each bit appears for one cycle with strobe high; frame_first_o marks the
// first bit and last_o the final one. The receiver cannot stall.
// A command frame is built as soon as the request is taken; a display frame
// is built once the shift-and-add-3 digit conversion has finished.
// One bit per cycle leaves the output shifter; a frame follows the one before
// it with no gap when it is already queued, so the sustained request rate is
// set by the output shifter. A two-entry queue lets new requests be taken
// while a frame is still being sent. Reset clears all control state; no
// frame is in flight afterwards.
`timescale 1ns / 1ps

module segment_lcd_serial_frame_writer import slfw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               kind_i,
  input  logic [CMD_W-1:0]   command_byte_i,
  input  logic [VALUE_W-1:0] value_i,
  input  logic               point_flag_i,
  output logic               strobe,
  output logic               serial_bit_o,
  output logic               frame_first_o,
  output logic               last_o
);

  frame_t push_frame;
  frame_t pop_frame;
  logic   push;
  logic   pop;
  logic   full;
  logic   empty;

  slfw_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .command_byte_i (command_byte_i),
    .value_i        (value_i),
    .point_flag_i   (point_flag_i),
    .full_i         (full),
    .push_o         (push),
    .frame_o        (push_frame)
  );

  slfw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .frame_i (push_frame),
    .pop_i   (pop),
    .frame_o (pop_frame),
    .full_o  (full),
    .empty_o (empty)
  );

  slfw_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_i       (pop_frame),
    .empty_i       (empty),
    .pop_o         (pop),
    .strobe        (strobe),
    .serial_bit_o  (serial_bit_o),
    .frame_first_o (frame_first_o),
    .last_o        (last_o)
  );

endmodule

// ===== design/slfw_front.sv =====
// Front end: accepts requests, converts display values to decimal
// digits and builds the left-aligned frame word. Depends on slfw_pkg.
`timescale 1ns / 1ps

module slfw_front import slfw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               kind_i,
  input  logic [CMD_W-1:0]   command_byte_i,
  input  logic [VALUE_W-1:0] value_i,
  input  logic               point_flag_i,
  input  logic               full_i,
  output logic               push_o,
  output frame_t             frame_o
);

  localparam int unsigned CNT_W = $clog2(VALUE_W + 1);

  typedef enum logic {
    S_IDLE,
    S_CONV
  } state_e;

  state_e             state_q;
  logic               fr_valid_q;
  frame_t             fr_q;
  logic               point_q;
  logic [VALUE_W-1:0] bin_q;
  logic [BCD_W-1:0]   bcd_q;
  logic [CNT_W-1:0]   cnt_q;

  logic [VALUE_W-1:0] clamped;
  logic [BCD_W-1:0]   bcd_adj;
  logic [BCD_W-1:0]   bcd_d;
  logic [FRAME_W-1:0] disp_bits;
  logic [FRAME_W-1:0] cmd_bits;
  logic               accept;
  logic               fr_load;

  assign busy    = (state_q == S_CONV) || (fr_valid_q && full_i);
  assign accept  = start && !busy;
  assign push_o  = fr_valid_q && !full_i;
  assign frame_o = fr_q;
  assign fr_load = (accept && !kind_i) ||
                   ((state_q == S_CONV) && (cnt_q == CNT_W'(VALUE_W)) &&
                    (!fr_valid_q || push_o));

  always_comb begin
    if ({{(CMP_W - VALUE_W){1'b0}}, value_i} > CMP_W'(MAX_VALUE)) begin
      clamped = VALUE_W'(MAX_VALUE);
    end else begin
      clamped = value_i;
    end
  end

  always_comb begin
    for (int d = 0; d < DIGIT_COUNT; d++) begin
      if (bcd_q[4*d +: 4] >= 4'd5) begin
        bcd_adj[4*d +: 4] = bcd_q[4*d +: 4] + 4'd3;
      end else begin
        bcd_adj[4*d +: 4] = bcd_q[4*d +: 4];
      end
    end
    bcd_d = {bcd_adj[BCD_W-2:0], bin_q[VALUE_W-1]};
  end

  always_comb begin
    logic [7:0] seg;
    logic       add;
    disp_bits = '0;
    disp_bits[FRAME_W-1 -: 3] = DISP_HEAD;
    for (int d = 0; d < DIGIT_COUNT; d++) begin
      seg = seg_code(bcd_q[4*d +: 4]);
      add = (d == 1) ? !point_q : point_q;
      if (add) begin
        seg = seg | POINT_SEG;
      end
      disp_bits[8*d +: 8] = seg;
    end
    cmd_bits = {CMD_HEAD, command_byte_i, {(FRAME_W - CMD_LEN){1'b0}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      fr_valid_q <= 1'b0;
      cnt_q      <= '0;
    end else begin
      fr_valid_q <= fr_load || (fr_valid_q && !push_o);
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            point_q <= point_flag_i;
            bin_q   <= clamped;
            bcd_q   <= '0;
            cnt_q   <= '0;
            if (kind_i) begin
              state_q <= S_CONV;
            end else begin
              fr_q.bits <= cmd_bits;
              fr_q.len  <= LEN_W'(CMD_LEN);
            end
          end
        end
        S_CONV: begin
          if (cnt_q != CNT_W'(VALUE_W)) begin
            bcd_q <= bcd_d;
            bin_q <= bin_q << 1;
            cnt_q <= cnt_q + 1'b1;
          end else if (!fr_valid_q || push_o) begin
            fr_q.bits <= disp_bits;
            fr_q.len  <= LEN_W'(FRAME_W);
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/slfw_queue.sv =====
// Two-entry queue of frame words between front and back ends.
// Depends on slfw_pkg.
`timescale 1ns / 1ps

module slfw_queue import slfw_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  frame_t frame_i,
  input  logic   pop_i,
  output frame_t frame_o,
  output logic   full_o,
  output logic   empty_o
);

  frame_t     mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign frame_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= frame_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

// ===== design/slfw_back.sv =====
// Back end: shifts frame words out one bit per cycle, MSB first.
// Depends on slfw_pkg.
`timescale 1ns / 1ps

module slfw_back import slfw_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  frame_t frame_i,
  input  logic   empty_i,
  output logic   pop_o,
  output logic   strobe,
  output logic   serial_bit_o,
  output logic   frame_first_o,
  output logic   last_o
);

  logic               active_q;
  logic               first_q;
  logic [FRAME_W-1:0] sh_q;
  logic [LEN_W-1:0]   cnt_q;
  logic               at_end;

  assign at_end        = (cnt_q == LEN_W'(1));
  assign pop_o         = (!active_q || at_end) && !empty_i;
  assign strobe        = active_q;
  assign serial_bit_o  = sh_q[FRAME_W-1];
  assign frame_first_o = first_q;
  assign last_o        = at_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      first_q  <= 1'b0;
      cnt_q    <= '0;
    end else if (!active_q || at_end) begin
      if (pop_o) begin
        active_q <= 1'b1;
        first_q  <= 1'b1;
        sh_q     <= frame_i.bits;
        cnt_q    <= frame_i.len;
      end else begin
        active_q <= 1'b0;
        first_q  <= 1'b0;
        cnt_q    <= '0;
      end
    end else begin
      first_q <= 1'b0;
      sh_q    <= sh_q << 1;
      cnt_q   <= cnt_q - 1'b1;
    end
  end

endmodule
